/* design/kmd_pkg.sv */
// Shared types, constants and the note lookup of the keyboard debouncer.
`timescale 1ns / 1ps
package kmd_pkg;

   localparam int LEVEL_W     = 24;  // width of one raw level sample word
   localparam int THR_W       = 4;   // width of the majority threshold
   localparam int KEY_W       = 5;   // width of key_index on the result channel
   localparam int NOTE_W      = 5;   // width of note_number
   localparam int QUEUE_DEPTH = 4;   // entries of the event queue, a power of two
   localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
   localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);
   localparam int NOTE_KEYS   = 24;
   localparam logic [THR_W-1:0] THR_RESET = 4'd5;

   localparam logic [NOTE_W-1:0] NOTE_TABLE [NOTE_KEYS] = '{
      5'd0,  5'd2,  5'd4,  5'd5,  5'd7,  5'd9,  5'd11, 5'd1,
      5'd3,  5'd6,  5'd8,  5'd10, 5'd12, 5'd14, 5'd16, 5'd17,
      5'd19, 5'd21, 5'd23, 5'd13, 5'd15, 5'd18, 5'd20, 5'd22
   };

   typedef struct packed {
      logic [KEY_W-1:0]  key_index;
      logic [NOTE_W-1:0] note_number;
      logic              is_press;
      logic              last_event;
   } kmd_event_type;

   typedef struct packed {
      logic          valid;
      kmd_event_type data;
   } kmd_push_type;

   // Keys past the table take their own index, masked to the note width.
   function automatic logic [NOTE_W-1:0] note_of(input logic [5:0] key);
      logic [NOTE_W-1:0] note;
      if (key < 6'(NOTE_KEYS)) begin
         note = NOTE_TABLE[key[4:0]];
      end else begin
         note = key[NOTE_W-1:0];
      end
      return note;
   endfunction

endpackage

/* design/keyboard_majority_debounce_events.sv */
// Top level of the majority-vote keyboard debouncer with press/release events.
//
//   channel  direction  handshake              payload
//   req      in         req_valid/req_ready    req_raw_levels[23:0]
//   rsp      out        rsp_valid/rsp_ready    rsp_key_index, rsp_note_number,
//                                              rsp_is_press, rsp_last_event
//   csr      in         csr_wr_en (no wait)    csr_wr_data[3:0] (majority threshold)
//
// A transaction walks the keys one at a time through the single shared majority datapath,
// then releases the final held event, all with req_ready low; the next transaction can
// be accepted once the scan and the final release are done.
// Events pass a four-entry queue, one per cycle while it has room. A held event facing a full queue stalls
// the scan in place; rsp_ready low stalls the output, then the scan once the queue fills.
// Synchronous reset clears key histories and held states and sets the threshold to 5.
`timescale 1ns / 1ps
module keyboard_majority_debounce_events #(
   parameter int NUM_KEYS = 24,
   parameter int WINDOW   = 8
) (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           req_valid,
   output logic                           req_ready,
   input  logic [kmd_pkg::LEVEL_W-1:0]    req_raw_levels,
   output logic                           rsp_valid,
   input  logic                           rsp_ready,
   output logic [kmd_pkg::KEY_W-1:0]      rsp_key_index,
   output logic [kmd_pkg::NOTE_W-1:0]     rsp_note_number,
   output logic                           rsp_is_press,
   output logic                           rsp_last_event,
   input  logic                           csr_wr_en,
   input  logic [kmd_pkg::THR_W-1:0]      csr_wr_data
);

   // Majority threshold: ones (or zeros) in the window needed to decide a level.
   logic [kmd_pkg::THR_W-1:0]  thr_ff, thr_in;
   kmd_pkg::kmd_push_type      push;
   kmd_pkg::kmd_push_type      head;
   logic                       queue_full;
   logic                       pop;

   // Hold the threshold unless software writes it.
   assign thr_in = csr_wr_en ? csr_wr_data : thr_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         thr_ff <= kmd_pkg::THR_RESET;
      end else begin
         thr_ff <= thr_in;
      end
   end

   // Front: accept a sample word and walk the keys, producing events in key order.
   kmd_front #(
      .NUM_KEYS (NUM_KEYS),
      .WINDOW   (WINDOW)
   ) u_front (
      .clock          (clock),
      .reset          (reset),
      .req_valid      (req_valid),
      .req_ready      (req_ready),
      .req_raw_levels (req_raw_levels),
      .threshold      (thr_ff),
      .queue_full     (queue_full),
      .push           (push)
   );

   // Queue: decouple the scan from response backpressure.
   kmd_queue u_queue (
      .clock (clock),
      .reset (reset),
      .push  (push),
      .full  (queue_full),
      .head  (head),
      .pop   (pop)
   );

   // Back: registered response stage.
   kmd_back u_back (
      .clock           (clock),
      .reset           (reset),
      .head            (head),
      .pop             (pop),
      .rsp_valid       (rsp_valid),
      .rsp_ready       (rsp_ready),
      .rsp_key_index   (rsp_key_index),
      .rsp_note_number (rsp_note_number),
      .rsp_is_press    (rsp_is_press),
      .rsp_last_event  (rsp_last_event)
   );

endmodule

/* design/kmd_front.sv */
// Key scanner: history ring, majority decision and event generation.
`timescale 1ns / 1ps
module kmd_front #(
   parameter int NUM_KEYS = 24,
   parameter int WINDOW   = 8
) (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            req_valid,
   output logic                            req_ready,
   input  logic [kmd_pkg::LEVEL_W-1:0]     req_raw_levels,
   input  logic [kmd_pkg::THR_W-1:0]       threshold,
   input  logic                            queue_full,
   output kmd_pkg::kmd_push_type           push
);

   localparam int IdxW = (NUM_KEYS > 1) ? $clog2(NUM_KEYS) : 1;
   localparam int CntW = $clog2(WINDOW + 1);
   localparam int CmpW = (CntW > kmd_pkg::THR_W) ? CntW : kmd_pkg::THR_W;
   localparam logic [IdxW-1:0] LastIdx = IdxW'(NUM_KEYS - 1);

   logic                          busy_ff, busy_in;
   logic                          flush_ff, flush_in;
   logic [IdxW-1:0]               idx_ff, idx_in;
   logic [kmd_pkg::LEVEL_W-1:0]   levels_ff, levels_in;
   logic                          pend_vld_ff, pend_vld_in;
   kmd_pkg::kmd_event_type        pend_ff, pend_in;
   logic [WINDOW-1:0]             hist_ff [NUM_KEYS];
   logic [WINDOW-1:0]             hist_in [NUM_KEYS];
   logic                          held_ff [NUM_KEYS];
   logic                          held_in [NUM_KEYS];

   logic [WINDOW-1:0]             new_hist;
   logic [CntW-1:0]               ones;
   logic [CmpW-1:0]               ones_c, zeros_c, thr_c;
   logic                          decide_hi, decide_lo, change;
   logic                          scan, advance, accept;
   logic                          want_push;
   kmd_pkg::kmd_event_type        new_ev;

   always_comb begin
      new_hist = {hist_ff[0][WINDOW-2:0], levels_ff[0]};
      ones = '0;
      for (int b = 0; b < WINDOW; b++) begin
         ones = ones + CntW'(new_hist[b]);
      end
      ones_c    = CmpW'(ones);
      zeros_c   = CmpW'(WINDOW) - ones_c;
      thr_c     = CmpW'(threshold);
      decide_hi = (ones_c >= thr_c);
      decide_lo = !decide_hi && (zeros_c >= thr_c);
      change    = (decide_hi || decide_lo) && (decide_hi != held_ff[0]);

      new_ev.key_index   = kmd_pkg::KEY_W'(idx_ff);
      new_ev.note_number = kmd_pkg::note_of(6'(idx_ff));
      new_ev.is_press    = decide_hi;
      new_ev.last_event  = 1'b0;

      scan      = busy_ff && !flush_ff;
      accept    = req_valid && !busy_ff;
      // The held event goes out when a newer one replaces it, or at the end.
      want_push  = pend_vld_ff && (scan ? change : flush_ff);
      advance    = !(want_push && queue_full);
      push.valid = want_push && !queue_full;
      push.data  = pend_ff;
      push.data.last_event = flush_ff;
   end

   always_comb begin
      busy_in     = busy_ff;
      flush_in    = flush_ff;
      idx_in      = idx_ff;
      levels_in   = levels_ff;
      pend_vld_in = pend_vld_ff;
      pend_in     = pend_ff;
      for (int j = 0; j < NUM_KEYS; j++) begin
         hist_in[j] = hist_ff[j];
         held_in[j] = held_ff[j];
      end
      if (accept) begin
         busy_in     = 1'b1;
         flush_in    = 1'b0;
         idx_in      = '0;
         levels_in   = req_raw_levels;
         pend_vld_in = 1'b0;
      end else if (scan && advance) begin
         // Rotate the ring: the current key leaves the head and rejoins at the tail.
         for (int j = 0; j < NUM_KEYS - 1; j++) begin
            hist_in[j] = hist_ff[j+1];
            held_in[j] = held_ff[j+1];
         end
         hist_in[NUM_KEYS-1] = new_hist;
         held_in[NUM_KEYS-1] = change ? decide_hi : held_ff[0];
         levels_in = levels_ff >> 1;
         if (change) begin
            pend_in     = new_ev;
            pend_vld_in = 1'b1;
         end
         if (idx_ff == LastIdx) begin
            flush_in = 1'b1;
         end else begin
            idx_in = idx_ff + IdxW'(1);
         end
      end else if (flush_ff && advance) begin
         busy_in     = 1'b0;
         flush_in    = 1'b0;
         pend_vld_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      levels_ff <= levels_in;
      pend_ff   <= pend_in;
      if (reset) begin
         busy_ff     <= 1'b0;
         flush_ff    <= 1'b0;
         idx_ff      <= '0;
         pend_vld_ff <= 1'b0;
         for (int j = 0; j < NUM_KEYS; j++) begin
            hist_ff[j] <= '0;
            held_ff[j] <= 1'b0;
         end
      end else begin
         busy_ff     <= busy_in;
         flush_ff    <= flush_in;
         idx_ff      <= idx_in;
         pend_vld_ff <= pend_vld_in;
         for (int j = 0; j < NUM_KEYS; j++) begin
            hist_ff[j] <= hist_in[j];
            held_ff[j] <= held_in[j];
         end
      end
   end

   assign req_ready = !busy_ff;

`ifndef SYNTH
   a_flush_only_when_busy: assert property (@(posedge clock) disable iff (reset)
      flush_ff |-> busy_ff)
      else $error("flush phase outside of a scan");
   a_stall_holds_ring: assert property (@(posedge clock) disable iff (reset)
      (busy_ff && !advance) |=> ($stable(hist_ff[0]) && $stable(idx_ff)))
      else $error("key ring moved while the queue was full");
   a_last_marks_end: assert property (@(posedge clock) disable iff (reset)
      (push.valid && advance && push.data.last_event) |=> !busy_ff)
      else $error("final event pushed but scan did not finish");
`endif

endmodule

/* design/kmd_queue.sv */
// Small event queue between the key scanner and the result register.
`timescale 1ns / 1ps
module kmd_queue (
   input  logic                   clock,
   input  logic                   reset,
   input  kmd_pkg::kmd_push_type  push,
   output logic                   full,
   output kmd_pkg::kmd_push_type  head,
   input  logic                   pop
);

   kmd_pkg::kmd_event_type               mem_ff [kmd_pkg::QUEUE_DEPTH];
   logic [kmd_pkg::QPTR_W-1:0]           wr_ptr_ff, wr_ptr_in;
   logic [kmd_pkg::QPTR_W-1:0]           rd_ptr_ff, rd_ptr_in;
   logic [kmd_pkg::QCNT_W-1:0]           count_ff, count_in;
   logic                                 do_pop;

   always_comb begin
      full       = (count_ff == kmd_pkg::QCNT_W'(kmd_pkg::QUEUE_DEPTH));
      head.valid = (count_ff != '0);
      head.data  = mem_ff[rd_ptr_ff];
      do_pop     = pop && head.valid;
      wr_ptr_in  = push.valid ? wr_ptr_ff + kmd_pkg::QPTR_W'(1) : wr_ptr_ff;
      rd_ptr_in  = do_pop ? rd_ptr_ff + kmd_pkg::QPTR_W'(1) : rd_ptr_ff;
      count_in   = count_ff;
      if (push.valid && !do_pop) begin
         count_in = count_ff + kmd_pkg::QCNT_W'(1);
      end else if (!push.valid && do_pop) begin
         count_in = count_ff - kmd_pkg::QCNT_W'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (push.valid) begin
         mem_ff[wr_ptr_ff] <= push.data;
      end
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

`ifndef SYNTH
   a_no_overflow: assert property (@(posedge clock) disable iff (reset)
      full |-> !push.valid || do_pop)
      else $error("event pushed into a full queue");
   a_count_tracks_ptrs: assert property (@(posedge clock) disable iff (reset)
      (count_ff != '0 && !full) |-> (wr_ptr_ff != rd_ptr_ff))
      else $error("queue pointers disagree with fill count");
`endif

endmodule

/* design/kmd_back.sv */
// Result register: drains the event queue onto the response channel.
`timescale 1ns / 1ps
module kmd_back (
   input  logic                           clock,
   input  logic                           reset,
   input  kmd_pkg::kmd_push_type          head,
   output logic                           pop,
   output logic                           rsp_valid,
   input  logic                           rsp_ready,
   output logic [kmd_pkg::KEY_W-1:0]      rsp_key_index,
   output logic [kmd_pkg::NOTE_W-1:0]     rsp_note_number,
   output logic                           rsp_is_press,
   output logic                           rsp_last_event
);

   logic                    out_vld_ff, out_vld_in;
   kmd_pkg::kmd_event_type  out_ff, out_in;

   always_comb begin
      // Load a fresh event whenever the register is empty or being taken.
      pop        = head.valid && (!out_vld_ff || rsp_ready);
      out_vld_in = pop ? 1'b1 : (out_vld_ff && !rsp_ready);
      out_in     = pop ? head.data : out_ff;
   end

   always_ff @(posedge clock) begin
      out_ff <= out_in;
      if (reset) begin
         out_vld_ff <= 1'b0;
      end else begin
         out_vld_ff <= out_vld_in;
      end
   end

   assign rsp_valid       = out_vld_ff;
   assign rsp_key_index   = out_ff.key_index;
   assign rsp_note_number = out_ff.note_number;
   assign rsp_is_press    = out_ff.is_press;
   assign rsp_last_event  = out_ff.last_event;

endmodule
